@@ design/nps_pkg.sv @@
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants for the nine-patch border scanner
// Field widths, result kinds, line operations and the result record.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int MAX_LINE  = 4096;
  localparam int POS_W     = $clog2(MAX_LINE);
  localparam int SUM_W     = POS_W + 1;
  localparam int COLOR_W   = 32;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = RES_PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_RANGE   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_PADDING = 2'd2
  } kind_t;

  typedef enum logic {
    OP_STRETCH = 1'b0,
    OP_PADDING = 1'b1
  } op_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   range_start;
    logic [POS_W-1:0]   range_end;
    logic [SUM_W-1:0]   fixed_length;
    logic               padding_found;
    logic [POS_W-1:0]   pad_lead;
    logic [POS_W-1:0]   pad_trail;
    logic               line_too_short;
    logic               last;
  } result_t;

  // Writes into the result queue for one processed pixel: slot 0, then slot 1.
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  localparam result_t RESULT_ZERO = '0;

endpackage

@@ design/nine_patch_border_scan.sv @@
// ----------------------------------------------------------------------------
// nine_patch_border_scan: nine-patch border marker decoder
// Results of a pixel pass from the pixel register through the result queue
//   to the result port.
// One pixel beat per cycle while the result queue has room; a line end that
//   gives two results is absorbed by the 4-entry result queue.
// Rate is set by the single pixel register feeding the state update.
// Reset (rst, sync, high): line state back to position 0, queue emptied.
// ----------------------------------------------------------------------------
module nine_patch_border_scan (
  input  logic                        clk,
  input  logic                        rst,
  // pixel channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [nps_pkg::COLOR_W-1:0] pixel_color,
  input  logic                        last_pixel,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  result_kind,
  output logic [nps_pkg::POS_W-1:0]   range_start,
  output logic [nps_pkg::POS_W-1:0]   range_end,
  output logic [nps_pkg::SUM_W-1:0]   fixed_length,
  output logic                        padding_found,
  output logic [nps_pkg::POS_W-1:0]   pad_lead,
  output logic [nps_pkg::POS_W-1:0]   pad_trail,
  output logic                        line_too_short,
  output logic                        last
);
  import nps_pkg::*;

  push_t   push;
  result_t res0;
  result_t res1;
  result_t head;
  logic    room;

  // Scan core: one pixel per cycle while the queue has room. Stretch lines
  // give a range beat per closed marked run (whole interior if none) and a
  // summary beat at line end; padding lines give one beat at line end.
  nps_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel),
    .room        (room),
    .push        (push),
    .res0        (res0),
    .res1        (res1)
  );

  // Result queue decouples the output handshake from pixel intake.
  nps_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign result_kind    = head.kind;
  assign range_start    = head.range_start;
  assign range_end      = head.range_end;
  assign fixed_length   = head.fixed_length;
  assign padding_found  = head.padding_found;
  assign pad_lead       = head.pad_lead;
  assign pad_trail      = head.pad_trail;
  assign line_too_short = head.line_too_short;
  assign last           = head.last;

endmodule

@@ design/nps_core.sv @@
// ----------------------------------------------------------------------------
// nps_core: pixel register, line state and result decode
// Holds one accepted pixel, updates the per-line scan state and emits up to
// two result records into the queue in the cycle it is processed.
// ----------------------------------------------------------------------------
module nps_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     operation,
  input  logic [nps_pkg::COLOR_W-1:0] pixel_color,
  input  logic                     last_pixel,
  input  logic                     room,
  output nps_pkg::push_t           push,
  output nps_pkg::result_t         res0,
  output nps_pkg::result_t         res1
);
  import nps_pkg::*;

  // pixel register
  logic s_valid;
  logic s_op;
  logic s_marked;
  logic s_last;

  // line state
  logic [POS_W-1:0] position;
  op_t              line_mode;
  logic             prev_transparent;
  logic [POS_W-1:0] run_start;
  logic [POS_W-1:0] gap_start;
  logic [SUM_W-1:0] fixed_sum;
  logic             any_range;
  logic             pad_seen;
  logic [POS_W-1:0] pad_first;
  logic [POS_W-1:0] pad_latest;

  logic [POS_W-1:0] position_next;
  op_t              line_mode_next;
  logic             prev_transparent_next;
  logic [POS_W-1:0] run_start_next;
  logic [POS_W-1:0] gap_start_next;
  logic [SUM_W-1:0] fixed_sum_next;
  logic             any_range_next;
  logic             pad_seen_next;
  logic [POS_W-1:0] pad_first_next;
  logic [POS_W-1:0] pad_latest_next;

  logic             process;
  logic             first;
  logic             is_last;
  logic             too_short;
  logic [POS_W-1:0] gap_len;
  result_t          summary;

  assign process  = s_valid && room;
  assign in_ready = !s_valid || process;

  always_comb begin
    first   = (position == '0);
    is_last = s_last || (position == POS_W'(MAX_LINE - 1));
    too_short = is_last && (position <= POS_W'(1));

    // first pixel of a line: take the operation and start from a clean line
    line_mode_next        = first ? op_t'(s_op) : line_mode;
    prev_transparent_next = first ? 1'b1 : prev_transparent;
    run_start_next        = first ? '0 : run_start;
    gap_start_next        = first ? '0 : gap_start;
    fixed_sum_next        = first ? '0 : fixed_sum;
    any_range_next        = first ? 1'b0 : any_range;
    pad_seen_next         = first ? 1'b0 : pad_seen;
    pad_first_next        = first ? '0 : pad_first;
    pad_latest_next       = first ? '0 : pad_latest;
    position_next         = is_last ? '0 : position + POS_W'(1);

    gap_len = position - gap_start_next;
    push    = '0;
    res0    = RESULT_ZERO;
    res1    = RESULT_ZERO;
    summary = RESULT_ZERO;

    if (too_short) begin
      res0.kind           = (line_mode_next == OP_PADDING) ? KIND_PADDING : KIND_SUMMARY;
      res0.line_too_short = 1'b1;
      res0.last           = 1'b1;
      push.push0          = 1'b1;
    end else if (line_mode_next == OP_STRETCH) begin
      if (!s_marked) begin
        if (!prev_transparent_next) begin
          // run closes at this transparent pixel
          gap_start_next   = position;
          any_range_next   = 1'b1;
          res0.kind        = KIND_RANGE;
          res0.range_start = run_start_next;
          res0.range_end   = position;
          push.push0       = 1'b1;
        end else if (is_last) begin
          fixed_sum_next = fixed_sum_next + SUM_W'(gap_len) + SUM_W'(1);
        end
        prev_transparent_next = 1'b1;
      end else begin
        if (prev_transparent_next) begin
          run_start_next = position;
          fixed_sum_next = fixed_sum_next + SUM_W'(gap_len);
        end
        prev_transparent_next = 1'b0;
      end

      if (is_last) begin
        summary.kind         = KIND_SUMMARY;
        summary.fixed_length = any_range_next ? fixed_sum_next : '0;
        summary.last         = 1'b1;
        if (push.push0) begin
          res1       = summary;
          push.push1 = 1'b1;
        end else if (!any_range_next) begin
          // no run closed in the line: whole interior stretches
          res0.kind        = KIND_RANGE;
          res0.range_start = POS_W'(1);
          res0.range_end   = position;
          res1             = summary;
          push.push0       = 1'b1;
          push.push1       = 1'b1;
        end else begin
          res0       = summary;
          push.push0 = 1'b1;
        end
      end
    end else begin
      if (is_last) begin
        res0.kind = KIND_PADDING;
        res0.last = 1'b1;
        if (pad_seen_next) begin
          res0.padding_found = 1'b1;
          res0.pad_lead      = pad_first_next - POS_W'(1);
          res0.pad_trail     = (position - POS_W'(1)) - pad_latest_next;
        end
        push.push0 = 1'b1;
      end else if (s_marked) begin
        if (!first && !pad_seen_next) begin
          pad_seen_next  = 1'b1;
          pad_first_next = position;
        end
        pad_latest_next = position;
      end
    end

    if (!process) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid          <= 1'b0;
      position         <= '0;
      line_mode        <= OP_STRETCH;
      prev_transparent <= 1'b1;
      run_start        <= '0;
      gap_start        <= '0;
      fixed_sum        <= '0;
      any_range        <= 1'b0;
      pad_seen         <= 1'b0;
      pad_first        <= '0;
      pad_latest       <= '0;
    end else begin
      if (in_ready) begin
        s_valid <= in_valid;
      end
      if (process) begin
        position         <= position_next;
        line_mode        <= line_mode_next;
        prev_transparent <= prev_transparent_next;
        run_start        <= run_start_next;
        gap_start        <= gap_start_next;
        fixed_sum        <= fixed_sum_next;
        any_range        <= any_range_next;
        pad_seen         <= pad_seen_next;
        pad_first        <= pad_first_next;
        pad_latest       <= pad_latest_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_op     <= operation;
      s_marked <= (pixel_color != '0);
      s_last   <= last_pixel;
    end
  end

  a_second_is_line_end: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> (res1.last && !res0.last && push.push0))
    else $error("second result slot must carry the line end");

  a_line_end_resets_pos: assert property (@(posedge clk) disable iff (rst)
    ((push.push0 && res0.last) || push.push1) |=> (position == '0))
    else $error("position not rewound after line end");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.push0 || push.push1) |-> (room && s_valid))
    else $error("result pushed without room or without a pixel");

endmodule

@@ design/nps_res_fifo.sv @@
// ----------------------------------------------------------------------------
// nps_res_fifo: result queue
// Small queue of result records; takes up to two writes and one read a cycle.
// ----------------------------------------------------------------------------
module nps_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  nps_pkg::push_t   push,
  input  nps_pkg::result_t res0,
  input  nps_pkg::result_t res1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output nps_pkg::result_t head
);
  import nps_pkg::*;

  result_t                mem [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr;
  logic [RES_PTR_W-1:0]   rd_ptr;
  logic [RES_CNT_W-1:0]   count;
  logic                   pop;
  logic [RES_CNT_W-1:0]   n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign room      = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign head      = mem[rd_ptr];
  assign n_push    = RES_CNT_W'(push.push0) + RES_CNT_W'(push.push1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + n_push - RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= res0;
    end
    if (push.push1) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= res1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> push.push0)
    else $error("slot 1 written without slot 0");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && (n_push == '0)) |=> (count == $past(count) - RES_CNT_W'(1)))
    else $error("queue count wrong after read");

endmodule

@@ tb/nps_scan_checker.sv @@
// ----------------------------------------------------------------------------
// nps_scan_checker: result checker for the nine-patch border scanner
// Watches the pixel and result channels, predicts the ranges, summaries and
// padding offsets of every accepted pixel beat, and compares each result beat
// in order against that prediction.
// ----------------------------------------------------------------------------
module nps_scan_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          operation,
  input  logic [nps_pkg::COLOR_W-1:0]   pixel_color,
  input  logic                          last_pixel,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    result_kind,
  input  logic [nps_pkg::POS_W-1:0]     range_start,
  input  logic [nps_pkg::POS_W-1:0]     range_end,
  input  logic [nps_pkg::SUM_W-1:0]     fixed_length,
  input  logic                          padding_found,
  input  logic [nps_pkg::POS_W-1:0]     pad_lead,
  input  logic [nps_pkg::POS_W-1:0]     pad_trail,
  input  logic                          line_too_short,
  input  logic                          last,
  output int unsigned                   errors,
  output int unsigned                   waiting
);
  import nps_pkg::*;

  // line state of the scanner
  logic [POS_W-1:0] cur_pos;
  op_t              mode;
  logic             was_clear;
  logic [POS_W-1:0] run_pos;
  logic [POS_W-1:0] gap_pos;
  logic [SUM_W-1:0] fixed_acc;
  logic             range_seen;
  logic             pad_hit;
  logic [POS_W-1:0] pad_lo;
  logic [POS_W-1:0] pad_hi;

  result_t     expected_results[$];
  int unsigned results_seen;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    errors++;
  endtask

  function automatic void add_expected(input result_t r);
    expected_results = {expected_results, r};
  endfunction

  task automatic clear_line_state();
    was_clear  = 1'b1;
    run_pos    = '0;
    gap_pos    = '0;
    fixed_acc  = '0;
    range_seen = 1'b0;
    pad_hit    = 1'b0;
    pad_lo     = '0;
    pad_hi     = '0;
  endtask

  task automatic scan_pixel(input logic op, input logic [COLOR_W-1:0] color,
                            input logic lp);
    logic [POS_W-1:0] pos;
    logic             marked;
    logic             is_last;
    logic [SUM_W-1:0] len;
    logic [SUM_W-1:0] fl;
    logic [SUM_W-1:0] trail;
    result_t          r;
    pos     = cur_pos;
    marked  = (color != '0);
    is_last = lp || (pos == POS_W'(MAX_LINE - 1));
    len     = SUM_W'(pos) + SUM_W'(1);
    if (pos == '0) begin
      mode = op_t'(op);
      clear_line_state();
    end
    if (is_last && len <= SUM_W'(2)) begin
      // too short for any marker
      r = RESULT_ZERO;
      r.kind = (mode == OP_PADDING) ? KIND_PADDING : KIND_SUMMARY;
      r.line_too_short = 1'b1;
      r.last = 1'b1;
      add_expected(r);
      cur_pos = '0;
    end else begin
      if (mode == OP_STRETCH) begin
        if (!marked) begin
          if (!was_clear) begin
            // first clear pixel after a run closes it
            gap_pos    = pos;
            range_seen = 1'b1;
            r = RESULT_ZERO;
            r.kind        = KIND_RANGE;
            r.range_start = run_pos;
            r.range_end   = pos;
            add_expected(r);
          end else if (is_last) begin
            fixed_acc = fixed_acc + SUM_W'(pos - gap_pos) + SUM_W'(1);
          end
          was_clear = 1'b1;
        end else begin
          if (was_clear) begin
            run_pos   = pos;
            fixed_acc = fixed_acc + SUM_W'(pos - gap_pos);
          end
          was_clear = 1'b0;
        end
        if (is_last) begin
          fl = fixed_acc;
          if (!range_seen) begin
            // no range in the line: whole interior stretches
            r = RESULT_ZERO;
            r.kind        = KIND_RANGE;
            r.range_start = POS_W'(1);
            r.range_end   = pos;
            add_expected(r);
            fl = '0;
          end
          r = RESULT_ZERO;
          r.kind         = KIND_SUMMARY;
          r.fixed_length = fl;
          r.last         = 1'b1;
          add_expected(r);
        end
      end else begin
        if (is_last) begin
          r = RESULT_ZERO;
          r.kind = KIND_PADDING;
          r.last = 1'b1;
          if (pad_hit) begin
            trail = len - SUM_W'(2) - SUM_W'(pad_hi);
            r.padding_found = 1'b1;
            r.pad_lead      = pad_lo - POS_W'(1);
            r.pad_trail     = trail[POS_W-1:0];
          end
          add_expected(r);
        end else if (marked) begin
          if (pos >= POS_W'(1) && !pad_hit) begin
            pad_hit = 1'b1;
            pad_lo  = pos;
          end
          pad_hi = pos;
        end
      end
      cur_pos = is_last ? '0 : pos + POS_W'(1);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      cur_pos = '0;
      mode    = OP_STRETCH;
      clear_line_state();
      expected_results.delete();
      results_seen = 0;
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind           = kind_t'(result_kind);
        got.range_start    = range_start;
        got.range_end      = range_end;
        got.fixed_length   = fixed_length;
        got.padding_found  = padding_found;
        got.pad_lead       = pad_lead;
        got.pad_trail      = pad_trail;
        got.line_too_short = line_too_short;
        got.last           = last;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat, kind", 32'(result_kind), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind)
            report_mismatch("result_kind", 32'(got.kind), 32'(want.kind));
          if (got.range_start != want.range_start)
            report_mismatch("range_start", 32'(got.range_start),
                            32'(want.range_start));
          if (got.range_end != want.range_end)
            report_mismatch("range_end", 32'(got.range_end), 32'(want.range_end));
          if (got.fixed_length != want.fixed_length)
            report_mismatch("fixed_length", 32'(got.fixed_length),
                            32'(want.fixed_length));
          if (got.padding_found != want.padding_found)
            report_mismatch("padding_found", 32'(got.padding_found),
                            32'(want.padding_found));
          if (got.pad_lead != want.pad_lead)
            report_mismatch("pad_lead", 32'(got.pad_lead), 32'(want.pad_lead));
          if (got.pad_trail != want.pad_trail)
            report_mismatch("pad_trail", 32'(got.pad_trail), 32'(want.pad_trail));
          if (got.line_too_short != want.line_too_short)
            report_mismatch("line_too_short", 32'(got.line_too_short),
                            32'(want.line_too_short));
          if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        scan_pixel(operation, pixel_color, last_pixel);
    end
    waiting = unsigned'(expected_results.size());
  end

endmodule

@@ tb/nine_patch_border_scan_test.sv @@
// ----------------------------------------------------------------------------
// nine_patch_border_scan_test: stimulus and verdict for the border scanner
// Feeds stretch and padding marker lines: a short directed set, then random
// lines in four flow-control phases. A checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module nine_patch_border_scan_test;
  import nps_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 operation;
  logic [COLOR_W-1:0]   pixel_color;
  logic                 last_pixel;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           result_kind;
  logic [POS_W-1:0]     range_start;
  logic [POS_W-1:0]     range_end;
  logic [SUM_W-1:0]     fixed_length;
  logic                 padding_found;
  logic [POS_W-1:0]     pad_lead;
  logic [POS_W-1:0]     pad_trail;
  logic                 line_too_short;
  logic                 last;

  int unsigned errors;
  int unsigned waiting;

  // flow control knobs, percent of cycles
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned pixels_sent = 0;

  // phases: none, sender idles, receiver stalls, both
  int sender_idle[4] = '{0, 86, 0, 38};
  int recv_stall[4]  = '{0, 0, 86, 38};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nine_patch_border_scan uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .pixel_color    (pixel_color),
    .last_pixel     (last_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .range_start    (range_start),
    .range_end      (range_end),
    .fixed_length   (fixed_length),
    .padding_found  (padding_found),
    .pad_lead       (pad_lead),
    .pad_trail      (pad_trail),
    .line_too_short (line_too_short),
    .last           (last)
  );

  nps_scan_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .pixel_color    (pixel_color),
    .last_pixel     (last_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .range_start    (range_start),
    .range_end      (range_end),
    .fixed_length   (fixed_length),
    .padding_found  (padding_found),
    .pad_lead       (pad_lead),
    .pad_trail      (pad_trail),
    .line_too_short (line_too_short),
    .last           (last),
    .errors         (errors),
    .waiting        (waiting)
  );

  // result side: random backpressure, changed at the falling edge
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  // one pixel beat; called and returns at a falling edge
  task automatic send_pixel(input op_t op, input logic [COLOR_W-1:0] color,
                            input logic lp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    pixel_color <= color;
    last_pixel  <= lp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  // non-transparent color: single bits, all ones or anything nonzero
  function automatic logic [COLOR_W-1:0] marker_color();
    logic [COLOR_W-1:0] c;
    case ($urandom_range(3))
      0: c = 32'h1 << $urandom_range(31);
      1: c = '1;
      default: c = $urandom();
    endcase
    if (c == '0) c = 32'h8000_0000;
    return c;
  endfunction

  // one border line; operation only matters on the first pixel, so the rest
  // carry random noise there. close_line = 0 leaves last_pixel low throughout.
  task automatic send_line(input op_t mode, input int unsigned len,
                           input int unsigned mark_pct, input bit close_line);
    logic [COLOR_W-1:0] color;
    op_t                op;
    for (int unsigned i = 0; i < len; i++) begin
      color = ($urandom_range(99) < mark_pct) ? marker_color() : '0;
      op    = (i == 0) ? mode : op_t'($urandom_range(1));
      send_pixel(op, color, close_line && (i == len - 1));
    end
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)  return $urandom_range(2, 1);
    if (r < 80) return $urandom_range(24, 3);
    if (r < 96) return $urandom_range(120, 25);
    return $urandom_range(600, 121);
  endfunction

  // hold off the sender until every predicted result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned phase_start;
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_STRETCH;
    pixel_color = '0;
    last_pixel  = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed lines
    // single-pixel stretch line: too short
    send_pixel(OP_STRETCH, '0, 1'b1);
    // two-pixel padding line: too short
    send_pixel(OP_PADDING, '1, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b1);
    // two runs, the second closed by the final clear pixel
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_PADDING, 32'hFFFF_FFFF, 1'b0);
    send_pixel(OP_STRETCH, 32'h8000_0000, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_PADDING, 32'h0000_0001, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b1);
    // nothing marked: default range and zero fixed length
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_PADDING, '0, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b1);
    // run reaching the line end stays open
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_STRETCH, 32'h0000_0005, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_PADDING, 32'h0000_0007, 1'b1);
    // padding: mark at position 0 only moves the trail, last pixel ignored
    send_pixel(OP_PADDING, 32'h0001_0000, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_PADDING, 32'h0000_0100, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_STRETCH, '1, 1'b1);
    // padding with marks only at the ends: nothing found
    send_pixel(OP_PADDING, '1, 1'b0);
    send_pixel(OP_STRETCH, '0, 1'b0);
    send_pixel(OP_PADDING, '1, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct    = sender_idle[ph];
      stall_pct   = recv_stall[ph];
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < 488)
        send_line(op_t'($urandom_range(1)), pick_length(), $urandom_range(100), 1'b1);
      wait_drained();
    end

    stall_pct = 0;
    while (waiting != 0) @(negedge clk);
    // keep running so a stray beat past the pipeline gets caught
    repeat (12) @(negedge clk);
    if (errors == 0 && waiting == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // hang guard
  initial begin
    #10000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
